>>> sv/c2c_pkg.sv
// Shared types, codes and defaults for the COO to CSR converter.
package c2c_pkg;

    localparam int MAX_ROWS_DEF     = 1024;
    localparam int MAX_NONZEROS_DEF = 4096;
    localparam int VALUE_BITS_DEF   = 32;

    localparam int KEY_W      = 10;
    localparam int NUM_ROWS_W = 11;
    localparam int REQ_W      = 3;
    localparam int POS_W      = 13;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int VAL_PORT_W = 32;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND    = 3'd0,
        REQ_BUILD     = 3'd1,
        REQ_READ_PTR  = 3'd2,
        REQ_READ_ENT  = 3'd3,
        REQ_CLEAR     = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_KEY_RANGE = 3'd1,
        ST_FULL      = 3'd2,
        ST_POS_RANGE = 3'd3,
        ST_NOT_BUILT = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS   = 1'b0,
        CFG_TRANSPOSED = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT_KEY,
        S_CNT_UPD,
        S_PFX_RD,
        S_PFX_WR,
        S_FIL_RD,
        S_FIL_KEY,
        S_FIL_UPD,
        S_DONE,
        S_READ
    } state_t;

endpackage

>>> sv/c2c_ram.sv
// Generic single write port, single read port RAM with registered read data.
module c2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/coo_to_csr_converter.sv
// Append, clear and rejected requests: result registered in the cycle after accept; good reads
// pass through the RAM read register and then the result register. Build runs clear, count,
// prefix and fill passes in order, one row or entry at a time; the per-row cursor RAM has one read port.
// One transaction in flight; the next is taken as the previous result leaves.
// Reset clears control, counts and the built flag; RAM contents are left as they are.
module coo_to_csr_converter #(
    parameter int MAX_ROWS     = c2c_pkg::MAX_ROWS_DEF,
    parameter int MAX_NONZEROS = c2c_pkg::MAX_NONZEROS_DEF,
    parameter int VALUE_BITS   = c2c_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [c2c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c2c_pkg::NUM_ROWS_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [c2c_pkg::REQ_W-1:0]        req_type,
    input  logic [c2c_pkg::KEY_W-1:0]        row_index,
    input  logic [c2c_pkg::KEY_W-1:0]        col_index,
    input  logic [c2c_pkg::VAL_PORT_W-1:0]   entry_value,
    input  logic [c2c_pkg::POS_W-1:0]        read_position,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [c2c_pkg::STATUS_W-1:0]     status,
    output logic [c2c_pkg::POS_W-1:0]        row_pointer,
    output logic [c2c_pkg::KEY_W-1:0]        col_out,
    output logic [c2c_pkg::VAL_PORT_W-1:0]   value_out,
    output logic [c2c_pkg::POS_W-1:0]        entry_count
);

    localparam int KEY_W  = c2c_pkg::KEY_W;
    localparam int TRIP_W = 2 * KEY_W + VALUE_BITS;
    localparam int CSR_W  = KEY_W + VALUE_BITS;
    localparam int NZ_AW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int CNT_W  = $clog2(MAX_NONZEROS + 1);
    localparam int RI_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int OFF_AW = $clog2(MAX_ROWS + 1);
    localparam int IDX_W  = (CNT_W > OFF_AW) ? CNT_W : OFF_AW;

    c2c_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [CNT_W-1:0]               sum_reg, sum_next;
    logic [CNT_W-1:0]               total_reg, total_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           built_reg, built_next;
    logic [c2c_pkg::NUM_ROWS_W-1:0] num_rows_reg, num_rows_next;
    logic                           transposed_reg, transposed_next;
    logic                           rd_kind_reg, rd_kind_next;
    logic                           out_valid_reg, out_valid_next;

    logic [c2c_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [c2c_pkg::POS_W-1:0]      rp_reg, rp_next;
    logic [KEY_W-1:0]               col_reg, col_next;
    logic [c2c_pkg::VAL_PORT_W-1:0] val_reg, val_next;

    // RAM ports
    logic                 trip_wr_en, trip_rd_en;
    logic [TRIP_W-1:0]    trip_wr_data, trip_rd_data;
    logic [NZ_AW-1:0]     trip_rd_addr;
    logic                 cnt_wr_en, cnt_rd_en;
    logic [RI_AW-1:0]     cnt_wr_addr, cnt_rd_addr;
    logic [CNT_W-1:0]     cnt_wr_data, cnt_rd_data;
    logic                 off_wr_en, off_rd_en;
    logic [OFF_AW-1:0]    off_wr_addr;
    logic [CNT_W-1:0]     off_wr_data, off_rd_data;
    logic                 csr_wr_en, csr_rd_en;
    logic [CSR_W-1:0]     csr_wr_data, csr_rd_data;

    logic [OFF_AW-1:0]     nr;
    logic                  in_acc;
    logic                  out_free;
    logic [KEY_W-1:0]      key_in;
    logic [KEY_W-1:0]      other_in;
    logic [VALUE_BITS-1:0] val_in;
    logic                  store_full;
    logic                  key_bad;
    logic                  append_ok;
    logic                  ptr_ok;
    logic                  ent_ok;
    logic [KEY_W-1:0]      trip_key;
    logic                  trip_key_ok;
    logic [IDX_W-1:0]      idx_inc;
    logic                  last_entry;
    logic                  last_row;
    logic [CNT_W-1:0]      alu_b;
    logic [CNT_W-1:0]      alu_sum;

    // rows in use, saturated to 1..MAX_ROWS
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            nr = OFF_AW'(1);
        end
        else if (32'(num_rows_reg) > 32'(MAX_ROWS))
        begin
            nr = OFF_AW'(MAX_ROWS);
        end
        else
        begin
            nr = OFF_AW'(num_rows_reg);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == c2c_pkg::S_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;

    assign key_in     = transposed_reg ? col_index : row_index;
    assign other_in   = transposed_reg ? row_index : col_index;
    assign val_in     = VALUE_BITS'(entry_value);
    assign store_full = 32'(count_reg) >= 32'(MAX_NONZEROS);
    assign key_bad    = 32'(key_in) >= 32'(nr);
    assign append_ok  = in_acc && (req_type == c2c_pkg::REQ_APPEND) && !store_full && !key_bad;
    assign ptr_ok     = built_reg && (32'(read_position) <= 32'(nr));
    assign ent_ok     = built_reg && (32'(read_position) < 32'(total_reg))
                        && (32'(read_position) < 32'(MAX_NONZEROS));

    assign trip_key    = trip_rd_data[TRIP_W-1 -: KEY_W];
    assign trip_key_ok = 32'(trip_key) < 32'(nr);
    assign idx_inc     = idx_reg + IDX_W'(1);
    assign last_entry  = idx_inc == IDX_W'(count_reg);
    assign last_row    = idx_inc == IDX_W'(nr);

    // shared adder: cursor increment or running prefix sum
    assign alu_b   = (state_reg == c2c_pkg::S_PFX_WR) ? sum_reg : CNT_W'(1);
    assign alu_sum = cnt_rd_data + alu_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c2c_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (req_type)
                        c2c_pkg::REQ_BUILD:    state_next = c2c_pkg::S_CLR;
                        c2c_pkg::REQ_READ_PTR: state_next = ptr_ok ? c2c_pkg::S_READ
                                                                   : c2c_pkg::S_IDLE;
                        c2c_pkg::REQ_READ_ENT: state_next = ent_ok ? c2c_pkg::S_READ
                                                                   : c2c_pkg::S_IDLE;
                        default:               state_next = c2c_pkg::S_IDLE;
                    endcase
                end
            end
            c2c_pkg::S_CLR:
            begin
                if (last_row)
                begin
                    state_next = (count_reg == '0) ? c2c_pkg::S_PFX_RD : c2c_pkg::S_CNT_RD;
                end
            end
            c2c_pkg::S_CNT_RD:
            begin
                state_next = c2c_pkg::S_CNT_KEY;
            end
            c2c_pkg::S_CNT_KEY:
            begin
                if (trip_key_ok)
                begin
                    state_next = c2c_pkg::S_CNT_UPD;
                end
                else
                begin
                    state_next = last_entry ? c2c_pkg::S_PFX_RD : c2c_pkg::S_CNT_RD;
                end
            end
            c2c_pkg::S_CNT_UPD:
            begin
                state_next = last_entry ? c2c_pkg::S_PFX_RD : c2c_pkg::S_CNT_RD;
            end
            c2c_pkg::S_PFX_RD:
            begin
                state_next = c2c_pkg::S_PFX_WR;
            end
            c2c_pkg::S_PFX_WR:
            begin
                if (last_row)
                begin
                    state_next = (count_reg == '0) ? c2c_pkg::S_DONE : c2c_pkg::S_FIL_RD;
                end
                else
                begin
                    state_next = c2c_pkg::S_PFX_RD;
                end
            end
            c2c_pkg::S_FIL_RD:
            begin
                state_next = c2c_pkg::S_FIL_KEY;
            end
            c2c_pkg::S_FIL_KEY:
            begin
                if (trip_key_ok)
                begin
                    state_next = c2c_pkg::S_FIL_UPD;
                end
                else
                begin
                    state_next = last_entry ? c2c_pkg::S_DONE : c2c_pkg::S_FIL_RD;
                end
            end
            c2c_pkg::S_FIL_UPD:
            begin
                state_next = last_entry ? c2c_pkg::S_DONE : c2c_pkg::S_FIL_RD;
            end
            c2c_pkg::S_DONE,
            c2c_pkg::S_READ:
            begin
                if (out_free)
                begin
                    state_next = c2c_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = c2c_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, RAM controls and results
    always_comb
    begin
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        built_next      = built_reg;
        num_rows_next   = num_rows_reg;
        transposed_next = transposed_reg;
        rd_kind_next    = rd_kind_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        rp_next         = rp_reg;
        col_next        = col_reg;
        val_next        = val_reg;

        trip_wr_en   = 1'b0;
        trip_wr_data = {key_in, other_in, val_in};
        trip_rd_en   = 1'b0;
        trip_rd_addr = NZ_AW'(idx_reg);
        cnt_wr_en    = 1'b0;
        cnt_wr_addr  = RI_AW'(idx_reg);
        cnt_wr_data  = '0;
        cnt_rd_en    = 1'b0;
        cnt_rd_addr  = RI_AW'(idx_reg);
        off_wr_en    = 1'b0;
        off_wr_addr  = '0;
        off_wr_data  = '0;
        off_rd_en    = 1'b0;
        csr_wr_en    = 1'b0;
        csr_wr_data  = trip_rd_data[CSR_W-1:0];
        csr_rd_en    = 1'b0;

        case (state_reg)
            c2c_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    status_next    = c2c_pkg::ST_OK;
                    rp_next        = '0;
                    col_next       = '0;
                    val_next       = '0;
                    case (req_type)
                        c2c_pkg::REQ_APPEND:
                        begin
                            if (store_full)
                            begin
                                status_next = c2c_pkg::ST_FULL;
                            end
                            else if (key_bad)
                            begin
                                status_next = c2c_pkg::ST_KEY_RANGE;
                            end
                            else
                            begin
                                trip_wr_en = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                built_next = 1'b0;
                            end
                        end
                        c2c_pkg::REQ_BUILD:
                        begin
                            out_valid_next = 1'b0;
                            idx_next       = '0;
                            sum_next       = '0;
                        end
                        c2c_pkg::REQ_READ_PTR:
                        begin
                            rd_kind_next = 1'b0;
                            if (!built_reg)
                            begin
                                status_next = c2c_pkg::ST_NOT_BUILT;
                            end
                            else if (!ptr_ok)
                            begin
                                status_next = c2c_pkg::ST_POS_RANGE;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                off_rd_en      = 1'b1;
                            end
                        end
                        c2c_pkg::REQ_READ_ENT:
                        begin
                            rd_kind_next = 1'b1;
                            if (!built_reg)
                            begin
                                status_next = c2c_pkg::ST_NOT_BUILT;
                            end
                            else if (!ent_ok)
                            begin
                                status_next = c2c_pkg::ST_POS_RANGE;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                csr_rd_en      = 1'b1;
                            end
                        end
                        c2c_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            built_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            c2c_pkg::S_CLR:
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_data = '0;
                if (idx_reg == '0)
                begin
                    off_wr_en = 1'b1;
                end
                idx_next = last_row ? '0 : idx_inc;
            end
            c2c_pkg::S_CNT_RD,
            c2c_pkg::S_FIL_RD:
            begin
                trip_rd_en = 1'b1;
            end
            c2c_pkg::S_CNT_KEY,
            c2c_pkg::S_FIL_KEY:
            begin
                cnt_rd_addr = RI_AW'(trip_key);
                if (trip_key_ok)
                begin
                    cnt_rd_en = 1'b1;
                end
                else
                begin
                    idx_next = last_entry ? '0 : idx_inc;
                end
            end
            c2c_pkg::S_CNT_UPD,
            c2c_pkg::S_FIL_UPD:
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = RI_AW'(trip_key);
                cnt_wr_data = alu_sum;
                csr_wr_en   = state_reg == c2c_pkg::S_FIL_UPD;
                idx_next    = last_entry ? '0 : idx_inc;
            end
            c2c_pkg::S_PFX_RD:
            begin
                cnt_rd_en = 1'b1;
            end
            c2c_pkg::S_PFX_WR:
            begin
                // offset of row k+1, and row k's cursor starts at offset k
                off_wr_en   = 1'b1;
                off_wr_addr = OFF_AW'(idx_inc);
                off_wr_data = alu_sum;
                cnt_wr_en   = 1'b1;
                cnt_wr_data = sum_reg;
                sum_next    = alu_sum;
                if (last_row)
                begin
                    total_next = alu_sum;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            c2c_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = c2c_pkg::ST_OK;
                    rp_next        = '0;
                    col_next       = '0;
                    val_next       = '0;
                    built_next     = 1'b1;
                end
            end
            c2c_pkg::S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = c2c_pkg::ST_OK;
                    if (rd_kind_reg)
                    begin
                        rp_next  = '0;
                        col_next = csr_rd_data[VALUE_BITS +: KEY_W];
                        val_next = c2c_pkg::VAL_PORT_W'(csr_rd_data[VALUE_BITS-1:0]);
                    end
                    else
                    begin
                        rp_next  = c2c_pkg::POS_W'(off_rd_data);
                        col_next = '0;
                        val_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                c2c_pkg::CFG_NUM_ROWS:   num_rows_next   = cfg_data;
                c2c_pkg::CFG_TRANSPOSED: transposed_next = cfg_data[0];
                default:
                begin
                end
            endcase
            built_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= c2c_pkg::S_IDLE;
            idx_reg        <= '0;
            sum_reg        <= '0;
            total_reg      <= '0;
            count_reg      <= '0;
            built_reg      <= 1'b0;
            num_rows_reg   <= c2c_pkg::NUM_ROWS_RST;
            transposed_reg <= 1'b0;
            rd_kind_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            built_reg      <= built_next;
            num_rows_reg   <= num_rows_next;
            transposed_reg <= transposed_next;
            rd_kind_reg    <= rd_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rp_reg     <= rp_next;
        col_reg    <= col_next;
        val_reg    <= val_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign row_pointer = rp_reg;
    assign col_out     = col_reg;
    assign value_out   = val_reg;
    assign entry_count = c2c_pkg::POS_W'(count_reg);

    c2c_ram #(
        .WIDTH (TRIP_W),
        .DEPTH (MAX_NONZEROS)
    ) u_trip_ram (
        .clk     (clk),
        .wr_en   (trip_wr_en),
        .wr_addr (NZ_AW'(count_reg)),
        .wr_data (trip_wr_data),
        .rd_en   (trip_rd_en),
        .rd_addr (trip_rd_addr),
        .rd_data (trip_rd_data)
    );

    c2c_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ROWS)
    ) u_cursor_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    c2c_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ROWS + 1)
    ) u_offset_ram (
        .clk     (clk),
        .wr_en   (off_wr_en),
        .wr_addr (off_wr_addr),
        .wr_data (off_wr_data),
        .rd_en   (off_rd_en),
        .rd_addr (OFF_AW'(read_position)),
        .rd_data (off_rd_data)
    );

    c2c_ram #(
        .WIDTH (CSR_W),
        .DEPTH (MAX_NONZEROS)
    ) u_csr_ram (
        .clk     (clk),
        .wr_en   (csr_wr_en),
        .wr_addr (NZ_AW'(cnt_rd_data)),
        .wr_data (csr_wr_data),
        .rd_en   (csr_rd_en),
        .rd_addr (NZ_AW'(read_position)),
        .rd_data (csr_rd_data)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_NONZEROS))
        else $error("triplet count beyond store depth");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        append_ok |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted append did not bump the count");

    a_build_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == c2c_pkg::S_CLR && idx_reg == '0) |-> !out_valid_reg)
        else $error("build started with a result still pending");

endmodule

>>> test/tb.sv
// Self-checking testbench for the COO to CSR converter: directed, full store, hold-off, random.
module tb;

    localparam int LIMIT_TIME = 16000000;

    localparam int KEY_W            = c2c_pkg::KEY_W;
    localparam int POS_W            = c2c_pkg::POS_W;
    localparam int REQ_W            = c2c_pkg::REQ_W;
    localparam int STATUS_W         = c2c_pkg::STATUS_W;
    localparam int CFG_IDX_W        = c2c_pkg::CFG_IDX_W;
    localparam int NUM_ROWS_W       = c2c_pkg::NUM_ROWS_W;
    localparam int VAL_PORT_W       = c2c_pkg::VAL_PORT_W;
    localparam int MAX_ROWS_DEF     = c2c_pkg::MAX_ROWS_DEF;
    localparam int MAX_NONZEROS_DEF = c2c_pkg::MAX_NONZEROS_DEF;

    typedef struct {
        c2c_pkg::status_t        status;
        logic [POS_W-1:0]        row_pointer;
        logic [KEY_W-1:0]        col_out;
        logic [VAL_PORT_W-1:0]   value_out;
        logic [POS_W-1:0]        entry_count;
    } csr_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [NUM_ROWS_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [REQ_W-1:0]        req_type = '0;
    logic [KEY_W-1:0]        row_index = '0;
    logic [KEY_W-1:0]        col_index = '0;
    logic [VAL_PORT_W-1:0]   entry_value = '0;
    logic [POS_W-1:0]        read_position = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        row_pointer;
    logic [KEY_W-1:0]        col_out;
    logic [VAL_PORT_W-1:0]   value_out;
    logic [POS_W-1:0]        entry_count;

    // Mirror of the converter state
    logic [NUM_ROWS_W-1:0]   rows_reg = c2c_pkg::NUM_ROWS_RST;
    bit                      transpose_reg = 1'b0;
    logic [KEY_W-1:0]        coo_key [MAX_NONZEROS_DEF];
    logic [KEY_W-1:0]        coo_other [MAX_NONZEROS_DEF];
    logic [VAL_PORT_W-1:0]   coo_val [MAX_NONZEROS_DEF];
    int unsigned             coo_count = 0;
    int unsigned             ptr_table [MAX_ROWS_DEF+1];
    logic [KEY_W-1:0]        csr_col [MAX_NONZEROS_DEF];
    logic [VAL_PORT_W-1:0]   csr_val [MAX_NONZEROS_DEF];
    bit                      csr_ready = 1'b0;

    csr_result_t             expected_results [$];
    int unsigned             mismatches = 0;
    int unsigned             requests_sent = 0;
    int unsigned             results_checked = 0;
    int unsigned             builds_seen = 0;
    int unsigned             send_idle_pct = 36;
    int unsigned             rcv_idle_pct = 49;
    int unsigned             hold_len = 0;
    int unsigned             hold_token = 0;
    int unsigned             hold_seen = 0;
    int unsigned             hold_left = 0;

    coo_to_csr_converter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .read_position (read_position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .row_pointer   (row_pointer),
        .col_out       (col_out),
        .value_out     (value_out),
        .entry_count   (entry_count)
    );

    always #4 clk = ~clk;

    function automatic int unsigned active_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > MAX_ROWS_DEF)
            return MAX_ROWS_DEF;
        return 32'(rows_reg);
    endfunction

    // Stable counting sort by key; entries whose key is now out of range are left out
    function automatic void rebuild_csr();
        int unsigned cursor [MAX_ROWS_DEF+1];
        int unsigned nr;
        int unsigned p;
        nr = active_rows();
        for (int k = 0; k <= MAX_ROWS_DEF; k++)
            cursor[k] = 0;
        for (int i = 0; i < coo_count; i++)
            if (coo_key[i] < nr)
                cursor[coo_key[i]]++;
        ptr_table[0] = 0;
        for (int k = 0; k < nr; k++)
        begin
            ptr_table[k+1] = ptr_table[k] + cursor[k];
            cursor[k] = ptr_table[k];
        end
        for (int i = 0; i < coo_count; i++)
        begin
            if (coo_key[i] < nr)
            begin
                p = cursor[coo_key[i]];
                cursor[coo_key[i]]++;
                csr_col[p] = coo_other[i];
                csr_val[p] = coo_val[i];
            end
        end
        csr_ready = 1'b1;
        builds_seen++;
    endfunction

    function automatic csr_result_t predict_request(input logic [REQ_W-1:0] req,
                                                    input logic [KEY_W-1:0] row,
                                                    input logic [KEY_W-1:0] col,
                                                    input logic [VAL_PORT_W-1:0] val,
                                                    input logic [POS_W-1:0] pos);
        csr_result_t r;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] other;
        int unsigned nr;
        r.status = c2c_pkg::ST_OK;
        r.row_pointer = '0;
        r.col_out = '0;
        r.value_out = '0;
        nr = active_rows();
        key = transpose_reg ? col : row;
        other = transpose_reg ? row : col;
        case (req)
            c2c_pkg::REQ_APPEND:
            begin
                if (coo_count >= MAX_NONZEROS_DEF)
                    r.status = c2c_pkg::ST_FULL;
                else if (key >= nr)
                    r.status = c2c_pkg::ST_KEY_RANGE;
                else
                begin
                    coo_key[coo_count] = key;
                    coo_other[coo_count] = other;
                    coo_val[coo_count] = val;
                    coo_count++;
                    csr_ready = 1'b0;
                end
            end
            c2c_pkg::REQ_BUILD:
                rebuild_csr();
            c2c_pkg::REQ_READ_PTR:
            begin
                if (!csr_ready)
                    r.status = c2c_pkg::ST_NOT_BUILT;
                else if (pos > nr)
                    r.status = c2c_pkg::ST_POS_RANGE;
                else
                    r.row_pointer = POS_W'(ptr_table[pos]);
            end
            c2c_pkg::REQ_READ_ENT:
            begin
                if (!csr_ready)
                    r.status = c2c_pkg::ST_NOT_BUILT;
                else if (pos >= ptr_table[nr] || pos >= MAX_NONZEROS_DEF)
                    r.status = c2c_pkg::ST_POS_RANGE;
                else
                begin
                    r.col_out = csr_col[pos];
                    r.value_out = csr_val[pos];
                end
            end
            c2c_pkg::REQ_CLEAR:
            begin
                coo_count = 0;
                csr_ready = 1'b0;
            end
            default:
                ;
        endcase
        r.entry_count = POS_W'(coo_count);
        return r;
    endfunction

    // One transaction on the input channel; returns just after the accepting edge
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] row,
                                input logic [KEY_W-1:0] col, input logic [VAL_PORT_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        row_index <= row;
        col_index <= col;
        entry_value <= val;
        read_position <= pos;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_request(req, row, col, val, pos));
        requests_sent++;
    endtask

    // Registers change only with nothing in flight
    task automatic write_register(input c2c_pkg::cfg_idx_t idx,
                                  input logic [NUM_ROWS_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == c2c_pkg::CFG_NUM_ROWS)
            rows_reg = data;
        else
            transpose_reg = data[0];
        csr_ready = 1'b0;
    endtask

    task automatic test_reads_and_extremes();
        logic [POS_W-1:0] ptr_probe [6] = '{13'd1, 13'd1023, 13'd1024, 13'd1025, 13'd4096, '1};
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd1024);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_APPEND, '0, '0, '0, '1);
        send_request(c2c_pkg::REQ_APPEND, '1, '1, '1, '0);
        send_request(c2c_pkg::REQ_APPEND, 10'd1023, 10'd5, 32'hA5A5_5A5A, '0);
        send_request(c2c_pkg::REQ_APPEND, '0, 10'd512, 32'd1, '0);
        // append after a build clears the built flag, so the read reports not built
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_BUILD, '1, '1, '1, '1);
        foreach (ptr_probe[i])
            send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, ptr_probe[i]);
        for (int i = 0; i < 5; i++)
            send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, POS_W'(i));
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, '1);
        for (int c = c2c_pkg::REQ_CLEAR + 1; c < (1 << REQ_W); c++)
            send_request(REQ_W'(c), KEY_W'($urandom), KEY_W'($urandom), $urandom,
                         POS_W'($urandom));
        send_request(c2c_pkg::REQ_CLEAR, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, '0);
    endtask

    task automatic test_keys_and_modes();
        write_register(c2c_pkg::CFG_NUM_ROWS, 11'd4);
        send_request(c2c_pkg::REQ_APPEND, 10'd4, 10'd7, 32'd11, '0);
        send_request(c2c_pkg::REQ_APPEND, 10'd3, 10'd1023, 32'd12, '0);
        send_request(c2c_pkg::REQ_APPEND, 10'd1, 10'd9, 32'd13, '0);
        // keys stored earlier keep their key across the mode change
        write_register(c2c_pkg::CFG_TRANSPOSED, 11'd1);
        send_request(c2c_pkg::REQ_APPEND, 10'd1000, 10'd2, 32'd14, '0);
        send_request(c2c_pkg::REQ_APPEND, 10'd1, 10'd4, 32'd15, '0);
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd4);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd5);
        for (int i = 0; i < 3; i++)
            send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, POS_W'(i));
        write_register(c2c_pkg::CFG_TRANSPOSED, 11'd1);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, '0);
        // lowering the row count leaves stale keys out of the next build
        write_register(c2c_pkg::CFG_NUM_ROWS, 11'd2);
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd2);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, 13'd1);
        write_register(c2c_pkg::CFG_NUM_ROWS, 11'd0);
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd1);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd2);
        write_register(c2c_pkg::CFG_NUM_ROWS, '1);
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd1024);
        send_request(c2c_pkg::REQ_CLEAR, '0, '0, '0, '0);
    endtask

    task automatic test_store_full();
        write_register(c2c_pkg::CFG_NUM_ROWS, 11'd1024);
        write_register(c2c_pkg::CFG_TRANSPOSED, 11'd0);
        send_request(c2c_pkg::REQ_CLEAR, '0, '0, '0, '0);
        while (coo_count < MAX_NONZEROS_DEF)
            send_request(c2c_pkg::REQ_APPEND, KEY_W'($urandom), KEY_W'($urandom), $urandom,
                         POS_W'($urandom));
        send_request(c2c_pkg::REQ_APPEND, KEY_W'($urandom), KEY_W'($urandom), $urandom,
                     POS_W'($urandom));
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, 13'd1024);
        send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, 13'd4095);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, 13'd4096);
        repeat (12)
        begin
            send_request(c2c_pkg::REQ_READ_PTR, '0, '0, '0, POS_W'($urandom_range(1024)));
            send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, POS_W'($urandom_range(4095)));
        end
        send_request(c2c_pkg::REQ_CLEAR, '0, '0, '0, '0);
    endtask

    // Output held off for a long stretch while the input keeps offering
    task automatic test_backpressure();
        int unsigned saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        hold_len = 120;
        hold_token++;
        repeat (10)
            send_request(c2c_pkg::REQ_APPEND, KEY_W'($urandom), KEY_W'($urandom), $urandom,
                         POS_W'($urandom));
        send_request(c2c_pkg::REQ_BUILD, '0, '0, '0, '0);
        send_request(c2c_pkg::REQ_READ_ENT, '0, '0, '0, 13'd9);
        send_idle_pct = saved_pct;
    endtask

    task automatic test_random_matrices(input int unsigned n_items, input int unsigned send_pct,
                                        input int unsigned rcv_pct);
        int unsigned start_count;
        int unsigned sel;
        int unsigned nr;
        int unsigned n_entries;
        int unsigned total;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] other;
        logic [VAL_PORT_W-1:0] val;
        logic [POS_W-1:0] pos;
        send_idle_pct = send_pct;
        rcv_idle_pct = rcv_pct;
        start_count = requests_sent;
        while (requests_sent - start_count < n_items)
        begin
            sel = $urandom_range(19);
            if (sel == 0)
                write_register(c2c_pkg::CFG_NUM_ROWS, 11'd1024);
            else if (sel == 1)
                write_register(c2c_pkg::CFG_NUM_ROWS, 11'd1);
            else if (sel == 2)
                write_register(c2c_pkg::CFG_NUM_ROWS, 11'd0);
            else if (sel == 3)
                write_register(c2c_pkg::CFG_NUM_ROWS, '1);
            else if (sel < 12)
                write_register(c2c_pkg::CFG_NUM_ROWS, NUM_ROWS_W'($urandom_range(64, 2)));
            if ($urandom_range(3) == 0)
                write_register(c2c_pkg::CFG_TRANSPOSED, NUM_ROWS_W'($urandom_range(1)));
            if (coo_count > 1200 || $urandom_range(9) != 0)
                send_request(c2c_pkg::REQ_CLEAR, KEY_W'($urandom), KEY_W'($urandom), $urandom,
                             POS_W'($urandom));
            nr = active_rows();
            n_entries = $urandom_range(40);
            for (int i = 0; i < n_entries; i++)
            begin
                key = ($urandom_range(9) == 0) ? KEY_W'($urandom)
                                               : KEY_W'($urandom_range(nr - 1));
                other = KEY_W'($urandom);
                case ($urandom_range(7))
                    0: val = '0;
                    1: val = '1;
                    default: val = $urandom;
                endcase
                if (transpose_reg)
                    send_request(c2c_pkg::REQ_APPEND, other, key, val, POS_W'($urandom));
                else
                    send_request(c2c_pkg::REQ_APPEND, key, other, val, POS_W'($urandom));
                if ($urandom_range(14) == 0)
                    send_request(REQ_W'($urandom), KEY_W'($urandom), KEY_W'($urandom),
                                 $urandom, POS_W'($urandom));
            end
            // now and then the build is missing, so the reads find nothing built
            if ($urandom_range(11) != 0)
                send_request(c2c_pkg::REQ_BUILD, KEY_W'($urandom), KEY_W'($urandom), $urandom,
                             POS_W'($urandom));
            repeat ($urandom_range(16, 4))
            begin
                if ($urandom_range(1) == 0)
                begin
                    pos = ($urandom_range(7) == 0) ? POS_W'($urandom)
                                                   : POS_W'($urandom_range(nr + 1));
                    send_request(c2c_pkg::REQ_READ_PTR, KEY_W'($urandom), KEY_W'($urandom),
                                 $urandom, pos);
                end
                else
                begin
                    total = csr_ready ? ptr_table[nr] : 0;
                    pos = ($urandom_range(7) == 0) ? POS_W'($urandom)
                                                   : POS_W'($urandom_range(total));
                    send_request(c2c_pkg::REQ_READ_ENT, KEY_W'($urandom), KEY_W'($urandom),
                                 $urandom, pos);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        csr_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("row_pointer", 32'(want.row_pointer), 32'(row_pointer));
                compare_field("col_out", 32'(want.col_out), 32'(col_out));
                compare_field("value_out", want.value_out, value_out);
                compare_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                results_checked++;
            end
        end
    end

    initial
    begin
        #LIMIT_TIME;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_reads_and_extremes();
        test_keys_and_modes();
        test_store_full();
        test_backpressure();
        test_random_matrices(570, 36, 49);
        test_random_matrices(570, 49, 36);
        test_random_matrices(570, 0, 0);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("summary: %0d requests sent, %0d results checked, %0d builds",
                 requests_sent, results_checked, builds_seen);
        $display("summary: directed edge cases, full store, output hold-off, random matrices");
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
